// File: sv/bal_pkg.sv
package bal_pkg;

	localparam int MODE_W      = 2;
	localparam int INDEX_W     = 4;
	localparam int VALUE_IN_W  = 32;
	localparam int VALUE_OUT_W = 32;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 5;

	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND = 2'd0,
		MODE_READ   = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_NONE   = 2'd3
	} bal_mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_EMPTY   = 2'd1,
		STATUS_INVALID = 2'd2,
		STATUS_FULL    = 2'd3
	} bal_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SHIFT,
		ST_RD_FIRST,
		ST_RD_LAST,
		ST_DONE
	} bal_state_t;

	typedef struct packed {
		logic [VALUE_OUT_W-1:0] read_value;
		bal_status_t            status;
		logic [COUNT_OUT_W-1:0] count;
		logic                   is_empty;
		logic [VALUE_OUT_W-1:0] first_value;
		logic [VALUE_OUT_W-1:0] last_value;
	} bal_result_t;

endpackage

// File: sv/bal_mem.sv
module bal_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/bal_ctrl.sv
module bal_ctrl #(
	parameter int CAPACITY_ENTRIES = 16,
	parameter int VALUE_WIDTH      = 32,
	parameter int AW               = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [bal_pkg::MODE_W-1:0]       mode,
	input  logic [bal_pkg::INDEX_W-1:0]      index,
	input  logic [bal_pkg::VALUE_IN_W-1:0]   value,
	output logic                             res_valid,
	input  logic                             res_take,
	output bal_pkg::bal_result_t             res,
	output logic                             mem_we,
	output logic [AW-1:0]                    mem_waddr,
	output logic [VALUE_WIDTH-1:0]           mem_wdata,
	output logic                             mem_re,
	output logic [AW-1:0]                    mem_raddr,
	input  logic [VALUE_WIDTH-1:0]           mem_rdata
);

	import bal_pkg::*;

	localparam int CW = $clog2(CAPACITY_ENTRIES + 1);
	localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY_ENTRIES);

	bal_state_t              state_q, state_d;
	bal_mode_t               mode_q;
	logic [INDEX_W-1:0]      index_q;
	logic [VALUE_IN_W-1:0]   value_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           ptr_q;
	logic                    pend_s1;
	logic [AW-1:0]           waddr_s1;
	bal_status_t             status_q;
	logic                    read_ok_q;
	logic [VALUE_OUT_W-1:0]  rdv_q;
	logic [VALUE_OUT_W-1:0]  first_q;

	logic [XW-1:0] idx_x;
	logic [XW-1:0] cnt_x;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] ptr_m1;
	logic          idx_bad;
	logic          full;
	logic          issue;
	logic          empty;
	logic          remove_ok;

	assign idx_x     = XW'(index_q);
	assign cnt_x     = XW'(count_q);
	assign cnt_m1    = count_q - CW'(1);
	assign ptr_m1    = ptr_q - CW'(1);
	assign idx_bad   = idx_x >= cnt_x;
	assign full      = count_q == CAP_C;
	assign empty     = count_q == '0;
	assign issue     = ptr_q < count_q;
	assign remove_ok = (mode_q == MODE_REMOVE) && !empty && !idx_bad;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_EXEC;
			ST_EXEC:     state_d = remove_ok ? ST_SHIFT : ST_RD_FIRST;
			ST_SHIFT:    if (!issue) state_d = ST_RD_FIRST;
			ST_RD_FIRST: state_d = ST_RD_LAST;
			ST_RD_LAST:  state_d = ST_DONE;
			ST_DONE:     if (res_take) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = state_q != ST_IDLE;
		res_valid = state_q == ST_DONE;
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = VALUE_WIDTH'(value_q);
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			ST_EXEC: begin
				mem_we    = (mode_q == MODE_APPEND) && !full;
				mem_re    = 1'b1;
				mem_raddr = idx_x[AW-1:0];
			end
			ST_SHIFT: begin
				// read entry ptr while the entry read last cycle lands one place lower
				mem_re    = issue;
				mem_raddr = ptr_q[AW-1:0];
				mem_we    = pend_s1;
				mem_waddr = waddr_s1;
				mem_wdata = mem_rdata;
			end
			ST_RD_FIRST: begin
				mem_re = 1'b1;
			end
			ST_RD_LAST: begin
				mem_re    = 1'b1;
				mem_raddr = cnt_m1[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_EXEC: begin
					pend_s1 <= 1'b0;
					if ((mode_q == MODE_APPEND) && !full) begin
						count_q <= count_q + CW'(1);
					end
				end
				ST_SHIFT: begin
					pend_s1 <= issue;
					if (!issue) begin
						count_q <= cnt_m1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					mode_q  <= bal_mode_t'(mode);
					index_q <= index;
					value_q <= value;
				end
			end
			ST_EXEC: begin
				rdv_q     <= '0;
				read_ok_q <= (mode_q == MODE_READ) && !idx_bad;
				ptr_q     <= CW'(idx_x + XW'(1));
				unique case (mode_q)
					MODE_APPEND: status_q <= full ? STATUS_FULL : STATUS_OK;
					MODE_READ:   status_q <= idx_bad ? STATUS_INVALID : STATUS_OK;
					MODE_REMOVE: begin
						if (empty) begin
							status_q <= STATUS_EMPTY;
						end else begin
							status_q <= idx_bad ? STATUS_INVALID : STATUS_OK;
						end
					end
					MODE_NONE: status_q <= STATUS_OK;
					default:   status_q <= STATUS_OK;
				endcase
			end
			ST_SHIFT: begin
				if (issue) begin
					ptr_q    <= ptr_q + CW'(1);
					waddr_s1 <= ptr_m1[AW-1:0];
				end
			end
			ST_RD_FIRST: begin
				if (read_ok_q) begin
					rdv_q <= VALUE_OUT_W'(mem_rdata);
				end
			end
			ST_RD_LAST: begin
				first_q <= VALUE_OUT_W'(mem_rdata);
			end
			default: begin
			end
		endcase
	end

	// last entry stays on the read port through the done state
	always_comb begin
		res.read_value  = rdv_q;
		res.status      = status_q;
		res.count       = COUNT_OUT_W'(count_q);
		res.is_empty    = empty;
		res.first_value = empty ? '0 : first_q;
		res.last_value  = empty ? '0 : VALUE_OUT_W'(mem_rdata);
	end

endmodule

// File: sv/bounded_array_list_top.sv
// Ordered list of up to CAPACITY_ENTRIES values held in a single-port-read,
// single-port-write memory with registered read data. One item is worked on
// at a time. Append, read, a remove that is refused and the idle mode pass
// through the execute, first-read, last-read and done states; a successful
// remove also shifts the entries above the removed one down one place, one entry per
// cycle through the memory's read and write ports. A finished result waits
// in an output register, so the next item is accepted while it is unclaimed.
module bounded_array_list_top #(
	parameter int CAPACITY_ENTRIES = 16,
	parameter int VALUE_WIDTH      = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [bal_pkg::MODE_W-1:0]       mode,
	input  logic [bal_pkg::INDEX_W-1:0]      index,
	input  logic [bal_pkg::VALUE_IN_W-1:0]   value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [bal_pkg::VALUE_OUT_W-1:0]  read_value,
	output logic [bal_pkg::STATUS_W-1:0]     status,
	output logic [bal_pkg::COUNT_OUT_W-1:0]  count,
	output logic                             is_empty,
	output logic [bal_pkg::VALUE_OUT_W-1:0]  first_value,
	output logic [bal_pkg::VALUE_OUT_W-1:0]  last_value
);

	import bal_pkg::*;

	localparam int AW = (CAPACITY_ENTRIES > 1) ? $clog2(CAPACITY_ENTRIES) : 1;

	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [VALUE_WIDTH-1:0] mem_wdata;
	logic                   mem_re;
	logic [AW-1:0]          mem_raddr;
	logic [VALUE_WIDTH-1:0] mem_rdata;
	logic                   res_valid;
	logic                   res_take;
	bal_result_t            res;
	bal_result_t            out_q;
	logic                   out_valid_q;

	bal_mem #(
		.DEPTH(CAPACITY_ENTRIES),
		.WIDTH(VALUE_WIDTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	bal_ctrl #(
		.CAPACITY_ENTRIES(CAPACITY_ENTRIES),
		.VALUE_WIDTH     (VALUE_WIDTH),
		.AW              (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.index    (index),
		.value    (value),
		.res_valid(res_valid),
		.res_take (res_take),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = out_q.read_value;
	assign status      = out_q.status;
	assign count       = out_q.count;
	assign is_empty    = out_q.is_empty;
	assign first_value = out_q.first_value;
	assign last_value  = out_q.last_value;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in flight");

	a_read_value_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STATUS_OK) |-> read_value == '0)
		else $error("read value set on a failed operation");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> (first_value == '0) && (last_value == '0) && (count == '0))
		else $error("empty list shows entries");

endmodule
